// ----- rtl/core/rtt_pkg.sv -----
`default_nettype none
package rtt_pkg;

	localparam int SLOTS_DEF = 16;

	localparam logic [2:0] OP_SCAN    = 3'd0;
	localparam logic [2:0] OP_CREATE  = 3'd1;
	localparam logic [2:0] OP_DESTROY = 3'd2;
	localparam logic [2:0] OP_PAUSE   = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	typedef enum logic [1:0] {
		KIND_FIRED  = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_ACCEPT = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  slot;
		logic [31:0] now;
		logic [23:0] delay;
		logic [15:0] reps;
		logic        pause_flag;
	} cmd_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] fired_slot;
		logic       completed;
		logic       last;
	} evt_t;

	typedef struct packed {
		logic [23:0] period;
		logic [15:0] limit;
		logic [15:0] count;
		logic [31:0] deadline;
		logic [31:0] pstart;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_RESUME,
		ST_ADV,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/core/rtt_ifs.sv -----
`default_nettype none
interface rtt_cmd_if import rtt_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtt_evt_if import rtt_pkg::*; ();
	logic valid;
	logic ready;
	evt_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rtt_alu.sv -----
`default_nettype none
module rtt_alu import rtt_pkg::*; (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic        sub,
	output logic      [31:0] sum
);

	assign sum = sub ? (a - b) : (a + b);

endmodule
`default_nettype wire

// ----- rtl/core/repeating_timer_table_core.sv -----
// Channel | Role   | Payload                                   | Transaction
// cmd     | sink   | op, slot, now, delay, reps, pause_flag    | valid & ready
// evt     | source | kind, fired_slot, completed, last         | valid & ready
//
// A command is taken only when the block is idle and nothing is awaiting delivery.
// Single-result operations pass through read, execute and output states; a resume adds
// a resume state. An update scan reads and checks each slot in turn, adds an advance
// state for a firing slot that keeps running, and an output state for each result.
// A result waits in its register for as long as the sink stalls, and the scan
// waits with it.
// Reset clears the in-use and paused flags; the timer memory is not cleared.
`default_nettype none
module repeating_timer_table_core import rtt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rtt_cmd_if.sink   cmd,
	rtt_evt_if.source evt
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	state_t             state_q, state_d;
	cmd_t               cmd_q;
	evt_t               res_q, res_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [31:0]        tmp_q, tmp_d;
	logic [SLOTS-1:0]   used_q, used_d;
	logic [SLOTS-1:0]   paused_q, paused_d;

	entry_t             tbl_q [SLOTS];
	entry_t             rd_q;
	entry_t             wr_data;
	logic               wr_en;

	logic [31:0]        alu_a, alu_b, alu_sum;
	logic               alu_sub;
	logic [15:0]        cnt_inc;
	logic               fin;
	logic               slot_ok;
	logic               ok;

	rtt_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (alu_sum)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign evt.valid = (state_q == ST_OUT);
	assign evt.data  = res_q;

	assign slot_ok = (32'(cmd_q.slot) < SLOTS);
	assign cnt_inc = rd_q.count + 16'd1;
	assign fin     = (rd_q.limit != 16'd0) && (cnt_inc >= rd_q.limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			used_q   <= '0;
			paused_q <= '0;
		end else begin
			state_q  <= state_d;
			used_q   <= used_d;
			paused_q <= paused_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.data;
		end
		idx_q <= idx_d;
		tmp_q <= tmp_d;
		res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_q[idx_q] <= wr_data;
		end
		rd_q <= tbl_q[idx_q];
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		tmp_d    = tmp_q;
		res_d    = res_q;
		used_d   = used_q;
		paused_d = paused_q;
		wr_en    = 1'b0;
		wr_data  = rd_q;
		alu_a    = cmd_q.now;
		alu_b    = rd_q.deadline;
		alu_sub  = 1'b1;
		ok       = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_READ;
					idx_d   = (cmd.data.op == OP_SCAN) ? '0 : IDX_W'(cmd.data.slot);
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_OUT;
				case (cmd_q.op)
					OP_SCAN: begin
						if (used_q[idx_q] && !paused_q[idx_q] && !alu_sum[31]) begin
							res_d = '{kind: KIND_FIRED, fired_slot: 4'(idx_q),
								completed: fin, last: 1'b0};
							if (fin) begin
								used_d[idx_q]   = 1'b0;
								paused_d[idx_q] = 1'b0;
							end else begin
								state_d = ST_ADV;
							end
						end else if (idx_q == LAST_IDX) begin
							res_d = '{kind: KIND_DONE, fired_slot: 4'd0,
								completed: 1'b0, last: 1'b1};
						end else begin
							idx_d   = idx_q + 1'b1;
							state_d = ST_READ;
						end
					end
					OP_CREATE: begin
						alu_b   = 32'(cmd_q.delay);
						alu_sub = 1'b0;
						if (slot_ok && !used_q[idx_q]) begin
							ok              = 1'b1;
							wr_en           = 1'b1;
							wr_data         = '{period: cmd_q.delay, limit: cmd_q.reps,
								count: 16'd0, deadline: alu_sum, pstart: 32'd0};
							used_d[idx_q]   = 1'b1;
							paused_d[idx_q] = 1'b0;
						end
					end
					OP_DESTROY: begin
						if (slot_ok && used_q[idx_q]) begin
							ok              = 1'b1;
							used_d[idx_q]   = 1'b0;
							paused_d[idx_q] = 1'b0;
						end
					end
					OP_PAUSE: begin
						alu_b = rd_q.pstart;
						if (slot_ok && used_q[idx_q]) begin
							ok = 1'b1;
							if (cmd_q.pause_flag) begin
								paused_d[idx_q] = 1'b1;
								wr_en           = 1'b1;
								wr_data.pstart  = cmd_q.now;
							end else if (paused_q[idx_q]) begin
								tmp_d   = alu_sum;
								state_d = ST_RESUME;
							end
						end
					end
					OP_CLEAR: begin
						ok       = 1'b1;
						used_d   = '0;
						paused_d = '0;
					end
					default: begin
						ok = 1'b0;
					end
				endcase
				if (cmd_q.op != OP_SCAN) begin
					res_d = '{kind: ok ? KIND_ACCEPT : KIND_REJECT,
						fired_slot: cmd_q.slot, completed: 1'b0, last: 1'b1};
				end
			end
			ST_RESUME: begin
				alu_a            = rd_q.deadline;
				alu_b            = tmp_q;
				alu_sub          = 1'b0;
				wr_en            = 1'b1;
				wr_data.deadline = alu_sum;
				wr_data.pstart   = 32'd0;
				paused_d[idx_q]  = 1'b0;
				state_d          = ST_OUT;
			end
			ST_ADV: begin
				alu_a            = rd_q.deadline;
				alu_b            = 32'(rd_q.period);
				alu_sub          = 1'b0;
				wr_en            = 1'b1;
				wr_data.deadline = alu_sum;
				if (rd_q.limit != 16'd0) begin
					wr_data.count = cnt_inc;
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (evt.ready) begin
					if (res_q.last) begin
						state_d = ST_IDLE;
					end else if (idx_q == LAST_IDX) begin
						res_d = '{kind: KIND_DONE, fired_slot: 4'd0,
							completed: 1'b0, last: 1'b1};
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/rtt_checker.sv -----
`default_nettype none
module rtt_checker import rtt_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_valid,
	input wire logic       cmd_ready,
	input wire logic       evt_valid,
	input wire logic       evt_ready,
	input wire logic [1:0] evt_kind,
	input wire logic       evt_last
);

	// A result waiting for the sink must stay offered until its transaction.
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid)
		else $error("result withdrawn before its transaction");

	// The block works on one command at a time.
	a_no_cmd_while_evt: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> !cmd_ready)
		else $error("command offered while a result is pending");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("ready straight after a command transaction");

	// Only firings may be followed by further results of the same command.
	a_nonlast_is_fired: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_last |-> evt_kind == KIND_FIRED)
		else $error("non-final result that is not a firing");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_kind == KIND_DONE |-> evt_last)
		else $error("scan done result without last");

endmodule

bind repeating_timer_table_core rtt_checker u_rtt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.evt_valid (evt.valid),
	.evt_ready (evt.ready),
	.evt_kind  (evt.data.kind),
	.evt_last  (evt.data.last)
);
`default_nettype wire

// ----- verif/timer_table_checker.sv -----
`default_nettype none
module timer_table_checker import rtt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire logic cmd_ready,
	input  wire cmd_t cmd_data,
	input  wire logic evt_valid,
	input  wire logic evt_ready,
	input  wire evt_t evt_data,
	output int        errors,
	output int        outstanding,
	output int        commands,
	output int        results,
	output int        firings
);

	logic        in_use     [SLOTS];
	logic        held       [SLOTS];
	logic [23:0] period_ms  [SLOTS];
	logic [15:0] rep_limit  [SLOTS];
	logic [15:0] tick_count [SLOTS];
	logic [31:0] due_at     [SLOTS];
	logic [31:0] held_since [SLOTS];

	evt_t expected_events[$];
	evt_t want;

	task automatic queue_event(input kind_t k, input int s, input logic done, input logic fin);
		evt_t e;
		e.kind       = k;
		e.fired_slot = 4'(s);
		e.completed  = done;
		e.last       = fin;
		expected_events.push_back(e);
	endtask

	task automatic run_timer_op(input cmd_t c);
		logic [31:0] lag;
		logic        done;
		logic        ok;
		int          i;
		ok = 1'b0;
		case (c.op)
			OP_SCAN: begin
				for (i = 0; i < SLOTS; i++) begin
					if (in_use[i] && !held[i]) begin
						lag = c.now - due_at[i];
						if (!lag[31]) begin
							done = 1'b0;
							if (rep_limit[i] != 16'd0) begin
								tick_count[i] = tick_count[i] + 16'd1;
								if (tick_count[i] >= rep_limit[i])
									done = 1'b1;
							end
							if (done) begin
								in_use[i] = 1'b0;
								held[i]   = 1'b0;
							end else begin
								due_at[i] = due_at[i] + 32'(period_ms[i]);
							end
							queue_event(KIND_FIRED, i, done, 1'b0);
							firings++;
						end
					end
				end
				queue_event(KIND_DONE, 0, 1'b0, 1'b1);
			end
			OP_CREATE: begin
				if (int'(c.slot) < SLOTS && !in_use[c.slot]) begin
					in_use[c.slot]     = 1'b1;
					held[c.slot]       = 1'b0;
					period_ms[c.slot]  = c.delay;
					rep_limit[c.slot]  = c.reps;
					tick_count[c.slot] = 16'd0;
					due_at[c.slot]     = c.now + 32'(c.delay);
					held_since[c.slot] = 32'd0;
					ok = 1'b1;
				end
			end
			OP_DESTROY: begin
				if (int'(c.slot) < SLOTS && in_use[c.slot]) begin
					in_use[c.slot] = 1'b0;
					held[c.slot]   = 1'b0;
					ok = 1'b1;
				end
			end
			OP_PAUSE: begin
				if (int'(c.slot) < SLOTS && in_use[c.slot]) begin
					if (c.pause_flag) begin
						held[c.slot]       = 1'b1;
						held_since[c.slot] = c.now;
					end else if (held[c.slot]) begin
						due_at[c.slot]     = due_at[c.slot] + (c.now - held_since[c.slot]);
						held_since[c.slot] = 32'd0;
						held[c.slot]       = 1'b0;
					end
					ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (i = 0; i < SLOTS; i++) begin
					in_use[i] = 1'b0;
					held[i]   = 1'b0;
				end
				ok = 1'b1;
			end
			default: ok = 1'b0;
		endcase
		if (c.op != OP_SCAN)
			queue_event(ok ? KIND_ACCEPT : KIND_REJECT, int'(c.slot), 1'b0, 1'b1);
	endtask

	task automatic check_field(input string what, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
			errors++;
		end
	endtask

	// Predictions for a transaction are queued at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				in_use[i] = 1'b0;
				held[i]   = 1'b0;
			end
			expected_events.delete();
			errors      = 0;
			outstanding = 0;
			commands    = 0;
			results     = 0;
			firings     = 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				commands++;
				run_timer_op(cmd_data);
			end
			if (evt_valid && evt_ready) begin
				results++;
				if (expected_events.size() == 0) begin
					$display("%0t: result with none expected, actual kind %0d slot %0d completed %0d last %0d",
						$time, evt_data.kind, evt_data.fired_slot, evt_data.completed,
						evt_data.last);
					errors++;
				end else begin
					want = expected_events.pop_front();
					check_field("kind", int'(want.kind), int'(evt_data.kind));
					check_field("fired_slot", int'(want.fired_slot), int'(evt_data.fired_slot));
					check_field("completed", int'(want.completed), int'(evt_data.completed));
					check_field("last", int'(want.last), int'(evt_data.last));
				end
			end
			outstanding = expected_events.size();
		end
	end

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none
module tb_top;
	import rtt_pkg::*;

	localparam int          ITEMS         = 200;
	localparam int          LIMIT         = 400000;
	localparam logic [2:0]  OP_UNUSED_MAX = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	int          errors;
	int          outstanding;
	int          commands;
	int          results;
	int          firings;
	int          cycles = 0;
	int          burst_left;
	int          stall_mode = 0;
	int          stall_left = 0;
	logic [31:0] wall_ms;

	rtt_cmd_if cmd_ch ();
	rtt_evt_if evt_ch ();

	repeating_timer_table_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.evt    (evt_ch)
	);

	timer_table_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_ch.valid),
		.cmd_ready   (cmd_ch.ready),
		.cmd_data    (cmd_ch.data),
		.evt_valid   (evt_ch.valid),
		.evt_ready   (evt_ch.ready),
		.evt_data    (evt_ch.data),
		.errors      (errors),
		.outstanding (outstanding),
		.commands    (commands),
		.results     (results),
		.firings     (firings)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = (stall_mode == 3) ? $urandom_range(1, 24) : $urandom_range(8, 80);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0:       evt_ch.ready <= 1'b1;
			1:       evt_ch.ready <= 1'($urandom_range(0, 1));
			2:       evt_ch.ready <= ($urandom_range(0, 3) == 0);
			default: evt_ch.ready <= 1'b0;
		endcase
	end

	function automatic cmd_t make_cmd(input logic [2:0] op, input logic [3:0] slot,
			input logic [31:0] now, input logic [23:0] delay, input logic [15:0] reps,
			input logic pf);
		cmd_t c;
		c.op         = op;
		c.slot       = slot;
		c.now        = now;
		c.delay      = delay;
		c.reps       = reps;
		c.pause_flag = pf;
		return c;
	endfunction

	task automatic send(input cmd_t c);
		cmd_ch.data  <= c;
		cmd_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_ch.valid <= 1'b0;
			burst_left = $urandom_range(0, 8);
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained;
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		cmd_t c;
		int   r;
		int   i;
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		evt_ch.ready = 1'b0;
		burst_left   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(make_cmd(OP_SCAN, 4'd0, 32'd0, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_DESTROY, 4'd3, 32'd0, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_PAUSE, 4'd3, 32'd0, 24'd0, 16'd0, 1'b1));
		send(make_cmd(OP_CREATE, 4'd0, 32'd0, 24'd0, 16'd1, 1'b0));
		send(make_cmd(OP_CREATE, 4'd0, 32'd0, 24'd7, 16'd2, 1'b0));
		send(make_cmd(OP_CREATE, 4'd15, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 1'b1));
		send(make_cmd(OP_CREATE, 4'd5, 32'd100, 24'd10, 16'd0, 1'b0));
		send(make_cmd(OP_CREATE, 4'd7, 32'd100, 24'd5, 16'd3, 1'b0));
		send(make_cmd(OP_SCAN, 4'd0, 32'd0, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_SCAN, 4'd0, 32'd110, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_PAUSE, 4'd5, 32'd115, 24'd0, 16'd0, 1'b1));
		send(make_cmd(OP_PAUSE, 4'd5, 32'd120, 24'd0, 16'd0, 1'b1));
		send(make_cmd(OP_SCAN, 4'd0, 32'd200, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_PAUSE, 4'd7, 32'd250, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_PAUSE, 4'd5, 32'd300, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_SCAN, 4'd0, 32'd300, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_SCAN, 4'd0, 32'd310 + 32'h7FFF_FFFF, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_SCAN, 4'd0, 32'd320 + 32'h8000_0000, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_DESTROY, 4'd5, 32'd0, 24'd0, 16'd0, 1'b0));
		for (i = int'(OP_CLEAR) + 1; i <= int'(OP_UNUSED_MAX); i++)
			send(make_cmd(3'(i), 4'd2, 32'd0, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_CLEAR, 4'd9, 32'd0, 24'd0, 16'd0, 1'b0));
		send(make_cmd(OP_SCAN, 4'd0, 32'hFFFF_FFFF, 24'd0, 16'd0, 1'b0));
		wait_drained();

		wall_ms = $urandom;
		for (i = 0; i < ITEMS; i++) begin
			c.op         = OP_SCAN;
			c.slot       = 4'($urandom_range(0, 15));
			c.now        = wall_ms;
			c.delay      = 24'($urandom);
			c.reps       = 16'($urandom);
			c.pause_flag = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 35) begin
				wall_ms = wall_ms + 32'($urandom_range(0, 40));
				c.now = wall_ms;
			end else if (r < 65) begin
				c.op = OP_CREATE;
				if ($urandom_range(0, 9) < 7)
					c.delay = 24'($urandom_range(0, 60));
				if ($urandom_range(0, 9) < 8)
					c.reps = 16'($urandom_range(0, 4));
			end else if (r < 73) begin
				c.op = OP_DESTROY;
			end else if (r < 88) begin
				c.op = OP_PAUSE;
			end else if (r < 91) begin
				c.op = OP_CLEAR;
			end else if (r < 94) begin
				c.op = 3'($urandom_range(int'(OP_CLEAR) + 1, int'(OP_UNUSED_MAX)));
			end else begin
				c.now = $urandom;
				if ($urandom_range(0, 1) == 1)
					wall_ms = c.now;
			end
			send(c);
			if (i == ITEMS / 2 || $urandom_range(0, 39) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (4 * SLOTS_DEF + 8) @(posedge clk);
		$display("Drove %0d commands through the timer table and checked %0d results,", commands,
			results);
		$display("of which %0d were timer firings across creates, pauses, resumes and scans.",
			firings);
		if (errors == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
